/* src/vn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;

	localparam int COMPONENT_WIDTH = 32;
	localparam int FRACTION_BITS = 16;
	localparam int UNIT_FRAC = 30;
	localparam int EPS_WIDTH = 16;
	localparam int EPS_FRAC = 16;
	localparam int OUT_WIDTH = 32;

	localparam int CW = COMPONENT_WIDTH;
	localparam int SW = 2 * COMPONENT_WIDTH;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef struct packed {
		logic signed [CW-1:0] x_in;
		logic signed [CW-1:0] y_in;
		logic signed [CW-1:0] z_in;
	} vec_item_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] x_unit;
		logic signed [OUT_WIDTH-1:0] y_unit;
		logic signed [OUT_WIDTH-1:0] z_unit;
		logic [OUT_WIDTH-1:0] magnitude;
		logic too_small;
	} res_item_t;

	// Entry passed from the front to the back through the queue.
	typedef struct packed {
		logic [SW-1:0] sum;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic [CW-1:0] az;
		logic [2:0] neg;
	} sq_item_t;

endpackage
`default_nettype wire

/* src/vec3_normalize.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// vec       in         push / full         vn_pkg::vec_item_t (x_in, y_in, z_in)
// res       out        pop / empty         vn_pkg::res_item_t (units, magnitude, too_small)
// cfg       in         cfg_valid/cfg_ready cfg_data = eps_threshold (16 bits)
//
// One vector per cycle sustained while results are popped; the path is 3 front stages, the queue, 32 root
// stages (one bit each) and 31 divider stages (one quotient bit each).
// Reset clears all valid flags and loads eps_threshold with 7.
// A result waiting on the output holds the back pipe; the 4-entry queue lets
// the front keep taking vectors until it fills, then full rises.
module vec3_normalize (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire vn_pkg::vec_item_t vec,
	input wire logic pop,
	output logic empty,
	output vn_pkg::res_item_t res,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [vn_pkg::EPS_WIDTH-1:0] cfg_data
);

	localparam int CW = vn_pkg::CW;

	logic [vn_pkg::EPS_WIDTH-1:0] eps_q;
	logic [CW-1:0] eps_scaled;
	logic q_push, q_room, q_pop, q_avail;
	vn_pkg::sq_item_t q_wdata, q_rdata;

	// Accept a register transfer every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) eps_q <= vn_pkg::EPS_WIDTH'(7);
		else if (cfg_valid && cfg_ready) eps_q <= cfg_data;
	end

	// Rescale the threshold to the component fraction width.
	always_comb begin
		if (vn_pkg::FRACTION_BITS >= vn_pkg::EPS_FRAC)
			eps_scaled = CW'(eps_q) << (vn_pkg::FRACTION_BITS - vn_pkg::EPS_FRAC);
		else
			eps_scaled = CW'(eps_q) >> (vn_pkg::EPS_FRAC - vn_pkg::FRACTION_BITS);
	end

	// Front: absolute values, squares, sum of squares.
	vn_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .vec(vec),
		.q_push(q_push), .q_room(q_room), .q_data(q_wdata)
	);

	// Decouple the front from the back.
	vn_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(q_push), .wdata(q_wdata), .room(q_room),
		.rd(q_pop), .avail(q_avail), .rdata(q_rdata)
	);

	// Back: square root, epsilon test, three divisions.
	vn_back u_back (
		.clk(clk), .arst_n(arst_n), .q_avail(q_avail), .q_data(q_rdata), .q_pop(q_pop),
		.eps(eps_scaled), .pop(pop), .empty(empty), .res(res)
	);

`ifndef ASSERT_OFF
	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.too_small) |-> (res.x_unit == '0 && res.y_unit == '0 &&
		res.z_unit == '0))
		else $error("too_small result carries a nonzero vector");

	a_big_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !res.too_small) |-> (res.magnitude != '0 &&
		res.magnitude >= eps_scaled))
		else $error("normalized result below threshold");

	a_hold_res: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(res)))
		else $error("waiting result changed");
`endif

endmodule
`default_nettype wire

/* src/vn_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module vn_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire vn_pkg::vec_item_t vec,
	output logic q_push,
	input wire logic q_room,
	output vn_pkg::sq_item_t q_data
);

	localparam int CW = vn_pkg::CW;
	localparam int SW = vn_pkg::SW;

	function automatic logic [CW-1:0] abs_f(input logic [CW-1:0] v);
		return v[CW-1] ? (~v + CW'(1)) : v;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3;
	logic [CW-1:0] ax_s1, ay_s1, az_s1, ax_s2, ay_s2, az_s2, ax_s3, ay_s3, az_s3;
	logic [2:0] neg_s1, neg_s2, neg_s3;
	logic [SW-1:0] px_s2, py_s2, pz_s2, sum_s3;

	// Advance all stages together; hold when the last one cannot drain.
	assign en = !v_s3 || q_room;
	assign full = !en;
	assign q_push = v_s3 && q_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= abs_f(vec.x_in);
			ay_s1 <= abs_f(vec.y_in);
			az_s1 <= abs_f(vec.z_in);
			neg_s1 <= {vec.x_in[CW-1], vec.y_in[CW-1], vec.z_in[CW-1]};
			px_s2 <= SW'(ax_s1) * SW'(ax_s1);
			py_s2 <= SW'(ay_s1) * SW'(ay_s1);
			pz_s2 <= SW'(az_s1) * SW'(az_s1);
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			az_s2 <= az_s1;
			neg_s2 <= neg_s1;
			sum_s3 <= px_s2 + py_s2 + pz_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			az_s3 <= az_s2;
			neg_s3 <= neg_s2;
		end
	end

	assign q_data = '{sum: sum_s3, ax: ax_s3, ay: ay_s3, az: az_s3, neg: neg_s3};

endmodule
`default_nettype wire

/* src/vn_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module vn_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	input wire vn_pkg::sq_item_t wdata,
	output logic room,
	input wire logic rd,
	output logic avail,
	output vn_pkg::sq_item_t rdata
);

	localparam int QAW = vn_pkg::QAW;

	vn_pkg::sq_item_t mem_q [vn_pkg::QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0] cnt_q;

	assign room = cnt_q != (QAW+1)'(vn_pkg::QDEPTH);
	assign avail = cnt_q != '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + QAW'(1);
			if (rd) rp_q <= rp_q + QAW'(1);
			if (wr && !rd) cnt_q <= cnt_q + (QAW+1)'(1);
			else if (rd && !wr) cnt_q <= cnt_q - (QAW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

/* src/vn_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module vn_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_avail,
	input wire vn_pkg::sq_item_t q_data,
	output logic q_pop,
	input wire logic [vn_pkg::CW-1:0] eps,
	input wire logic pop,
	output logic empty,
	output vn_pkg::res_item_t res
);

	localparam int CW = vn_pkg::CW;
	localparam int SW = vn_pkg::SW;
	localparam int RW = CW + 4;
	localparam int DW = CW + 2;
	localparam int NS = CW;
	localparam int ND = vn_pkg::UNIT_FRAC + 1;
	localparam int OW = vn_pkg::OUT_WIDTH;

	logic en;

	// Square root: one root bit per stage.
	logic sv_s [1:NS];
	logic [RW-1:0] rem_i [1:NS], rem_s [1:NS];
	logic [CW-1:0] root_i [1:NS], root_s [1:NS];
	logic [SW-1:0] s_i [1:NS], s_s [1:NS];
	logic [CW-1:0] sa_i [1:NS][3], sa_s [1:NS][3];
	logic [2:0] sn_i [1:NS], sn_s [1:NS];
	logic sv_i [1:NS];

	// Division: one quotient bit per stage, three lanes.
	logic dv_s [1:ND], dv_i [1:ND];
	logic [CW-1:0] m_i [1:ND], m_s [1:ND];
	logic sm_i [1:ND], sm_s [1:ND];
	logic [2:0] dn_i [1:ND], dn_s [1:ND];
	logic [DW-1:0] r_i [1:ND][3], r_s [1:ND][3];
	logic [ND-1:0] q_i [1:ND][3], q_s [1:ND][3];

	// Hold the whole back pipe while the result waits on the output.
	assign en = !dv_s[ND] || pop;
	assign q_pop = en && q_avail;
	assign empty = !dv_s[ND];

	genvar k, l;
	generate
		for (k = 1; k <= NS; k++) begin : g_sqrt
			logic [RW-1:0] rem_sh, trial;
			if (k == 1) begin : g_src
				assign sv_i[k] = q_avail;
				assign rem_i[k] = '0;
				assign root_i[k] = '0;
				assign s_i[k] = q_data.sum;
				assign sa_i[k][0] = q_data.ax;
				assign sa_i[k][1] = q_data.ay;
				assign sa_i[k][2] = q_data.az;
				assign sn_i[k] = q_data.neg;
			end else begin : g_prev
				assign sv_i[k] = sv_s[k-1];
				assign rem_i[k] = rem_s[k-1];
				assign root_i[k] = root_s[k-1];
				assign s_i[k] = s_s[k-1];
				assign sa_i[k] = sa_s[k-1];
				assign sn_i[k] = sn_s[k-1];
			end
			assign rem_sh = {rem_i[k][RW-3:0], s_i[k][SW-1:SW-2]};
			assign trial = {2'b00, root_i[k], 2'b01};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) sv_s[k] <= 1'b0;
				else if (en) sv_s[k] <= sv_i[k];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					if (rem_sh >= trial) begin
						rem_s[k] <= rem_sh - trial;
						root_s[k] <= {root_i[k][CW-2:0], 1'b1};
					end else begin
						rem_s[k] <= rem_sh;
						root_s[k] <= {root_i[k][CW-2:0], 1'b0};
					end
					s_s[k] <= {s_i[k][SW-3:0], 2'b00};
					sa_s[k] <= sa_i[k];
					sn_s[k] <= sn_i[k];
				end
			end
		end

		for (k = 1; k <= ND; k++) begin : g_div
			if (k == 1) begin : g_src
				assign dv_i[k] = sv_s[NS];
				assign m_i[k] = root_s[NS];
				assign sm_i[k] = (root_s[NS] < eps) || (root_s[NS] == '0);
				assign dn_i[k] = sn_s[NS];
				for (l = 0; l < 3; l++) begin : g_l
					assign r_i[k][l] = DW'(sa_s[NS][l]);
					assign q_i[k][l] = '0;
				end
			end else begin : g_prev
				assign dv_i[k] = dv_s[k-1];
				assign m_i[k] = m_s[k-1];
				assign sm_i[k] = sm_s[k-1];
				assign dn_i[k] = dn_s[k-1];
				for (l = 0; l < 3; l++) begin : g_l
					assign r_i[k][l] = {r_s[k-1][l][DW-2:0], 1'b0};
					assign q_i[k][l] = q_s[k-1][l];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) dv_s[k] <= 1'b0;
				else if (en) dv_s[k] <= dv_i[k];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					m_s[k] <= m_i[k];
					sm_s[k] <= sm_i[k];
					dn_s[k] <= dn_i[k];
				end
			end
			for (l = 0; l < 3; l++) begin : g_lane
				logic ge;
				assign ge = r_i[k][l] >= DW'(m_i[k]);
				always_ff @(posedge clk) begin
					if (en) begin
						r_s[k][l] <= ge ? (r_i[k][l] - DW'(m_i[k])) : r_i[k][l];
						q_s[k][l] <= {q_i[k][l][ND-2:0], ge};
					end
				end
			end
		end
	endgenerate

	function automatic logic [OW-1:0] sgn_f(input logic [ND-1:0] q, input logic n,
		input logic z);
		logic [OW-1:0] e;
		e = OW'(q);
		if (z) return '0;
		return n ? (~e + OW'(1)) : e;
	endfunction

	assign res.x_unit = sgn_f(q_s[ND][0], dn_s[ND][2], sm_s[ND]);
	assign res.y_unit = sgn_f(q_s[ND][1], dn_s[ND][1], sm_s[ND]);
	assign res.z_unit = sgn_f(q_s[ND][2], dn_s[ND][0], sm_s[ND]);
	assign res.magnitude = OW'(m_s[ND]);
	assign res.too_small = sm_s[ND];

endmodule
`default_nettype wire

/* bench/vec3_normalize_tb.sv */
`timescale 1ns / 1ps
module vec3_normalize_tb;

	// Expected normalization results, oldest first.
	class unit_scoreboard;
		vn_pkg::res_item_t pending[$];
		logic [15:0] eps;
		int mismatches;

		function new();
			eps = 16'd7;
			mismatches = 0;
		endfunction

		// Compute the unit vector of one accepted input and hold it.
		function void note_vector(vn_pkg::vec_item_t v);
			logic [31:0] ca[3];
			logic [2:0] neg;
			logic [127:0] sum;
			logic [63:0] mag, cand;
			logic [63:0] r, q;
			logic tiny;
			vn_pkg::res_item_t e;
			logic [31:0] u[3];
			ca[0] = v.x_in;
			ca[1] = v.y_in;
			ca[2] = v.z_in;
			sum = '0;
			for (int i = 0; i < 3; i++) begin
				neg[i] = ca[i][31];
				ca[i] = neg[i] ? (~ca[i] + 32'd1) : ca[i];
				sum = sum + 128'(ca[i]) * 128'(ca[i]);
			end
			mag = '0;
			for (int b = 31; b >= 0; b--) begin
				cand = mag | (64'd1 << b);
				if (128'(cand) * 128'(cand) <= sum)
					mag = cand;
			end
			tiny = (mag < 64'(eps)) || (mag == 0);
			for (int i = 0; i < 3; i++) begin
				q = 0;
				if (!tiny) begin
					r = 64'(ca[i]);
					if (r >= mag) begin
						r -= mag;
						q = 1;
					end
					for (int k = 0; k < 30; k++) begin
						r = r << 1;
						q = q << 1;
						if (r >= mag) begin
							r -= mag;
							q |= 1;
						end
					end
				end
				u[i] = neg[i] ? (32'd0 - q[31:0]) : q[31:0];
			end
			e.x_unit = u[0];
			e.y_unit = u[1];
			e.z_unit = u[2];
			e.magnitude = mag[31:0];
			e.too_small = tiny;
			pending.push_back(e);
		endfunction

		// Compare one popped result against the oldest expectation.
		function void check_result(vn_pkg::res_item_t got);
			vn_pkg::res_item_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
				return;
			end
			e = pending.pop_front();
			if (got.x_unit !== e.x_unit || got.y_unit !== e.y_unit
					|| got.z_unit !== e.z_unit || got.magnitude !== e.magnitude
					|| got.too_small !== e.too_small) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp x=%h y=%h z=%h m=%h s=%b got x=%h y=%h z=%h m=%h s=%b",
						e.x_unit, e.y_unit, e.z_unit, e.magnitude, e.too_small,
						got.x_unit, got.y_unit, got.z_unit, got.magnitude,
						got.too_small);
			end
		endfunction
	endclass

	localparam int LIMIT = 400000;

	logic clk, arst_n;
	logic push, full, pop, empty;
	vn_pkg::vec_item_t vec;
	vn_pkg::res_item_t res;
	logic cfg_valid, cfg_ready;
	logic [vn_pkg::EPS_WIDTH-1:0] cfg_data;

	unit_scoreboard sb;
	int cycles;
	bit calm;      // no idling in the last part of the run
	bit done;

	vec3_normalize u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .vec(vec),
		.pop(pop), .empty(empty), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the pipe hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[vec3_normalize] ERROR");
			$finish;
		end
	end

	// Drain side: pop in random bursts, check every transfer.
	int pop_idle;
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(res);
			if (pop_idle > 0) begin
				pop_idle <= pop_idle - 1;
				pop <= 0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				pop_idle <= $urandom_range(1, 15);
				pop <= 0;
			end else
				pop <= 1;
		end
	end

	// Random component: mixes extremes, small vectors and full-range values.
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(0, 40)) - 20);
			3: return 32'($signed($urandom_range(0, 2000)) - 1000);
			4: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			default: return $urandom;
		endcase
	endfunction

	// Offer one vector; hold it until the transfer. Push stays high so that
	// the next vector can follow at once; drain() drops it.
	task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 15);
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		vec <= '{x_in: x, y_in: y, z_in: z};
		push <= 1;
		do @(posedge clk); while (full);
		sb.note_vector('{x_in: x, y_in: y, z_in: z});
	endtask

	// Wait until every result has come back, plus the pipe depth.
	task automatic drain();
		push <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_eps(logic [15:0] v);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.eps = v;
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++)
			send_vec(rand_comp(), rand_comp(), rand_comp());
	endtask

	initial begin
		sb = new();
		cycles = 0;
		calm = 0;
		pop_idle = 0;
		arst_n = 0;
		push = 0;
		pop = 0;
		vec = '0;
		cfg_valid = 0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: zeros, extremes, axis vectors, around the reset epsilon.
		send_vec(0, 0, 0);
		send_vec(32'h8000_0000, 0, 0);
		send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vec(32'h7fff_ffff, 32'h8000_0000, 0);
		send_vec(32'h0001_0000, 0, 0);
		send_vec(0, 32'hffff_0000, 0);
		send_vec(0, 0, 32'h0001_0000);
		send_vec(6, 0, 0);
		send_vec(7, 0, 0);
		send_vec(4, 4, 4);
		send_vec(32'hffff_fffa, 0, 0);
		send_vec(1, 32'hffff_ffff, 1);
		send_vec(32'h0003_0000, 32'h0004_0000, 0);
		send_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		random_phase(200);
		drain();

		// Zero epsilon: zero length must still flag.
		write_eps(16'd0);
		send_vec(0, 0, 0);
		send_vec(1, 0, 0);
		random_phase(250);
		drain();

		// Largest epsilon: any magnitude below 0xffff flags.
		write_eps(16'hffff);
		send_vec(32'h0000_ffff, 0, 0);
		send_vec(32'h0001_0000, 0, 0);
		random_phase(250);
		drain();

		write_eps(16'h8000);
		random_phase(250);
		drain();

		write_eps(16'($urandom));
		random_phase(200);
		drain();

		// Last part without idling on either side.
		write_eps(16'd7);
		calm = 1;
		random_phase(170);
		drain();

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[vec3_normalize] OK");
		else
			$display("[vec3_normalize] ERROR");
		$finish;
	end
endmodule
